[sv/lcfc_pkg.sv]
`default_nettype none
package lcfc_pkg;
	localparam int VALUE_W         = 16;
	localparam int LEN_W           = 16;
	localparam int DIV_W           = 9;
	localparam int MAX_VALUE_DEF   = 65535;
	localparam int MAX_FACTORS_DEF = 6;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
endpackage
`default_nettype wire

[sv/lcfc_ram.sv]
`default_nettype none
module lcfc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[sv/lcfc_div.sv]
`default_nettype none
module lcfc_div
	import lcfc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [VALUE_W-1:0] dividend,
	input  wire logic [DIV_W-1:0]   divisor,
	output logic                    done,
	output logic      [VALUE_W-1:0] quotient,
	output logic      [DIV_W-1:0]   remainder
);
	localparam int CNT_W = $clog2(VALUE_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [VALUE_W-1:0] dvd_q;
	logic [DIV_W-1:0]   dsr_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W:0]     rem_sh;
	logic               fits;

	// one quotient bit per cycle, restoring
	assign rem_sh = {rem_q, dvd_q[VALUE_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_W-2:0], fits};
			rem_q <= fits ? DIV_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DIV_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

[sv/longest_common_factor_chain.sv]
// channel | signals                         | direction
// input   | in_valid, in_ready, value, first | into block
// result  | out_valid, out_ready,            | out of block
//         | chain_length, best_length        |
// after reset and for every item with first set, a pass over all MAX_VALUE+1
// entries zeroes the per-prime store; no item is taken during the pass after reset.
// an item runs trial divisors up to the square root of its remaining cofactor,
// repeats the division by each found prime, then reads and writes the store
// once per distinct prime; the one shared bit-serial divider does all divisions.
// a finished result waits in the output register while the next item is taken.
`default_nettype none
module longest_common_factor_chain
	import lcfc_pkg::*;
#(
	parameter int MAX_VALUE   = MAX_VALUE_DEF,
	parameter int MAX_FACTORS = MAX_FACTORS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic               first,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [LEN_W-1:0]   chain_length,
	output logic      [LEN_W-1:0]   best_length
);
	localparam int DEPTH = MAX_VALUE + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_FACTORS + 1);
	localparam int IW    = $clog2(MAX_FACTORS);

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_START = 9'b000000100,
		ST_TEST  = 9'b000001000,
		ST_DIV   = 9'b000010000,
		ST_RD    = 9'b000100000,
		ST_RDW   = 9'b001000000,
		ST_LEN   = 9'b010000000,
		ST_WR    = 9'b100000000
	} state_t;

	state_t             state_q;
	logic               pend_q;
	logic               done_q;
	logic [AW-1:0]      clr_q;
	logic [VALUE_W-1:0] v_q;
	logic [DIV_W-1:0]   d_q;
	logic               hit_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	logic [AW-1:0]      primes_q [MAX_FACTORS];
	logic [LEN_W-1:0]   top_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   best_q;
	logic               out_valid_q;
	logic [LEN_W-1:0]   chain_q;
	logic [LEN_W-1:0]   bestout_q;

	logic               div_start;
	logic [VALUE_W-1:0] div_dvd;
	logic               div_done;
	logic [VALUE_W-1:0] div_quot;
	logic [DIV_W-1:0]   div_rem;
	logic [2*DIV_W-1:0] d_sq;
	logic               in_range;
	logic               can_add;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [LEN_W-1:0]   mem_wdata;
	logic [LEN_W-1:0]   mem_rdata;
	logic               out_free;
	logic [LEN_W-1:0]   new_best;

	assign d_sq     = {{DIV_W{1'b0}}, d_q} * {{DIV_W{1'b0}}, d_q};
	assign in_range = (v_q >= VALUE_W'(2)) && (32'(v_q) <= 32'(MAX_VALUE));
	assign can_add  = cnt_q < CW'(MAX_FACTORS);
	assign out_free = !out_valid_q || out_ready;
	assign new_best = (len_q > best_q) ? len_q : best_q;

	assign in_ready = (state_q == ST_IDLE) && !done_q;

	// first division at a divisor, or again while it still divides
	always_comb begin
		div_start = 1'b0;
		div_dvd   = v_q;
		if (state_q == ST_TEST && d_sq <= {2'b00, v_q}) begin
			div_start = 1'b1;
		end else if (state_q == ST_DIV && div_done && div_rem == '0) begin
			div_start = 1'b1;
			div_dvd   = div_quot;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = primes_q[idx_q[IW-1:0]];
		mem_wdata = len_q;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_WR) begin
			mem_we = 1'b1;
		end
	end

	lcfc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (d_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	lcfc_ram #(
		.WIDTH (LEN_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (primes_q[idx_q[IW-1:0]]),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pend_q      <= 1'b0;
			done_q      <= 1'b0;
			clr_q       <= '0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// finished item waits here until the result register is free
			if (done_q && out_free) begin
				done_q      <= 1'b0;
				out_valid_q <= 1'b1;
				best_q      <= new_best;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_VALUE)) begin
						clr_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= pend_q ? ST_START : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (first) begin
							best_q  <= '0;
							pend_q  <= 1'b1;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					state_q <= in_range ? ST_TEST : ST_LEN;
				end
				ST_TEST: begin
					if (!div_start) begin
						state_q <= (cnt_q == '0 && !(v_q > VALUE_W'(1) && can_add))
							? ST_LEN : ST_RD;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done && div_rem != '0) begin
						state_q <= ST_TEST;
					end
				end
				ST_RD: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					state_q <= (idx_q == cnt_q - 1'b1) ? ST_LEN : ST_RD;
				end
				ST_LEN: begin
					state_q <= (cnt_q == '0) ? ST_IDLE : ST_WR;
					if (cnt_q == '0) begin
						done_q <= 1'b1;
					end
				end
				ST_WR: begin
					if (idx_q == cnt_q - 1'b1) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done_q && out_free) begin
			chain_q   <= len_q;
			bestout_q <= new_best;
		end
		case (state_q)
			ST_IDLE: begin
				v_q <= value;
			end
			ST_START: begin
				d_q   <= DIV_W'(2);
				hit_q <= 1'b0;
				cnt_q <= '0;
				idx_q <= '0;
				top_q <= '0;
			end
			ST_TEST: begin
				// leftover cofactor above one is the last prime
				if (!div_start && v_q > VALUE_W'(1) && can_add) begin
					primes_q[cnt_q[IW-1:0]] <= AW'(v_q);
					cnt_q                   <= cnt_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (div_rem == '0) begin
						if (!hit_q && can_add) begin
							primes_q[cnt_q[IW-1:0]] <= AW'(d_q);
							cnt_q                   <= cnt_q + 1'b1;
						end
						hit_q <= 1'b1;
						v_q   <= div_quot;
					end else begin
						hit_q <= 1'b0;
						d_q   <= d_q + 1'b1;
					end
				end
			end
			ST_RDW: begin
				if (mem_rdata > top_q) begin
					top_q <= mem_rdata;
				end
				idx_q <= (idx_q == cnt_q - 1'b1) ? '0 : idx_q + 1'b1;
			end
			ST_LEN: begin
				len_q <= (top_q == LEN_MAX) ? LEN_MAX : top_q + 1'b1;
				idx_q <= '0;
			end
			ST_WR: begin
				idx_q <= idx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign chain_length = chain_q;
	assign best_length  = bestout_q;
endmodule
`default_nettype wire

[sim/longest_common_factor_chain_test.sv]
`timescale 1ns / 1ps
module longest_common_factor_chain_test;
	import lcfc_pkg::*;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               first;
		logic               typed;
		logic [LEN_W-1:0]   chain;
		logic [LEN_W-1:0]   best;
	} row_t;

	typedef struct packed {
		logic [LEN_W-1:0] chain;
		logic [LEN_W-1:0] best;
	} lengths_t;

	localparam int N_DIRECTED = 15;
	localparam int N_RANDOM   = 1880;

	// typed expectations where the answer is obvious, the rest from the predictor
	row_t directed [N_DIRECTED] = '{
		'{16'd1,     1'b0, 1'b1, 16'd1, 16'd1},
		'{16'd0,     1'b0, 1'b1, 16'd1, 16'd1},
		'{16'd65535, 1'b0, 1'b1, 16'd1, 16'd1},
		'{16'd65521, 1'b0, 1'b1, 16'd1, 16'd1},
		'{16'd6,     1'b1, 1'b1, 16'd1, 16'd1},
		'{16'd10,    1'b0, 1'b1, 16'd2, 16'd2},
		'{16'd15,    1'b0, 1'b1, 16'd3, 16'd3},
		'{16'd7,     1'b0, 1'b1, 16'd1, 16'd3},
		'{16'd1,     1'b0, 1'b1, 16'd1, 16'd3},
		'{16'd30030, 1'b0, 1'b0, 16'd0, 16'd0},
		'{16'd32768, 1'b0, 1'b0, 16'd0, 16'd0},
		'{16'd65534, 1'b0, 1'b0, 16'd0, 16'd0},
		'{16'd2,     1'b1, 1'b1, 16'd1, 16'd1},
		'{16'd65535, 1'b0, 1'b1, 16'd1, 16'd1},
		'{16'd0,     1'b0, 1'b1, 16'd1, 16'd1}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [VALUE_W-1:0] value = '0;
	logic               first = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [LEN_W-1:0]   chain_length;
	logic [LEN_W-1:0]   best_length;

	logic [LEN_W-1:0] chain_by_prime [0:MAX_VALUE_DEF];
	logic [LEN_W-1:0] best_run;
	lengths_t         pending_lengths [$];
	int               errors = 0;
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;

	longest_common_factor_chain dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .value(value), .first(first),
		.out_valid(out_valid), .out_ready(out_ready),
		.chain_length(chain_length), .best_length(best_length)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic lengths_t chain_step(input logic [VALUE_W-1:0] v, input logic f);
		int unsigned r, d, top, len;
		int unsigned primes [MAX_FACTORS_DEF];
		int n;
		lengths_t res;
		if (f) begin
			foreach (chain_by_prime[i]) chain_by_prime[i] = '0;
			best_run = '0;
		end
		n = 0;
		top = 0;
		if (v >= 2) begin
			r = 32'(v);
			d = 2;
			while (d * d <= r) begin
				if (r % d == 0) begin
					if (n < MAX_FACTORS_DEF) begin
						primes[n] = d;
						n++;
					end
					while (r % d == 0) r = r / d;
				end
				d++;
			end
			if (r > 1 && n < MAX_FACTORS_DEF) begin
				primes[n] = r;
				n++;
			end
		end
		for (int i = 0; i < n; i++)
			if (chain_by_prime[primes[i]] > top) top = 32'(chain_by_prime[primes[i]]);
		len = top + 1;
		if (len > LEN_MAX) len = 32'(LEN_MAX);
		for (int i = 0; i < n; i++) chain_by_prime[primes[i]] = len[LEN_W-1:0];
		if (len > best_run) best_run = len[LEN_W-1:0];
		res.chain = len[LEN_W-1:0];
		res.best = best_run;
		return res;
	endfunction

	task automatic send_item(input logic [VALUE_W-1:0] v, input logic f,
			input logic typed, input lengths_t typed_lengths);
		int gap;
		lengths_t predicted;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		first <= f;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = chain_step(v, f);
		pending_lengths.push_back(typed ? typed_lengths : predicted);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_lengths.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && out_valid && out_ready) begin
			if (pending_lengths.size() == 0) begin
				$error("unexpected transfer: chain_length %0d best_length %0d",
					chain_length, best_length);
				errors++;
			end else begin
				if (chain_length !== pending_lengths[0].chain) begin
					$error("chain_length expected %0d actual %0d",
						pending_lengths[0].chain, chain_length);
					errors++;
				end
				if (best_length !== pending_lengths[0].best) begin
					$error("best_length expected %0d actual %0d",
						pending_lengths[0].best, best_length);
					errors++;
				end
				void'(pending_lengths.pop_front());
			end
		end
	end

	initial begin
		logic [VALUE_W-1:0] v;
		logic f;
		int pick;
		foreach (chain_by_prime[i]) chain_by_prime[i] = '0;
		best_run = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_item(directed[i].value, directed[i].first, directed[i].typed,
				'{directed[i].chain, directed[i].best});
		// hold off until the block has emptied out
		drain_results();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % (N_RANDOM / 4) == 0) begin
				drain_results();
				case (i / (N_RANDOM / 4))
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
					default: begin send_idle_pct = 37; recv_stall_pct = 37; end
				endcase
			end
			// small values keep trial division short and chains dense
			pick = $urandom_range(99);
			if (pick < 70) v = VALUE_W'($urandom_range(2, 600));
			else if (pick < 85) v = VALUE_W'($urandom_range(2, 4096));
			else if (pick < 95) v = VALUE_W'($urandom_range(0, 65535));
			else v = 16'd1;
			// a new sequence is costly: the store clear walks every entry
			f = ($urandom_range(199) == 0);
			send_item(v, f, 1'b0, '0);
		end

		drain_results();
		repeat (6000) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

[filelist.f]
sv/lcfc_pkg.sv
sv/lcfc_ram.sv
sv/lcfc_div.sv
sv/longest_common_factor_chain.sv
sim/longest_common_factor_chain_test.sv
